// File: rtl/core/fbpa_pkg.sv
// Package for the fixed block pool allocator: sizes, codes, FSM states and
// the structs passed between the allocator modules. No dependencies.
package fbpa_pkg;

   localparam int MAX_BLOCKS      = 1024;
   localparam int LINK_NODE_BYTES = 16;
   localparam int ADDR_BITS       = 48;

   localparam int IDX_W      = $clog2(MAX_BLOCKS);
   localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
   localparam int BYTES_W    = 16;
   localparam int ALIGN_W    = 13;
   localparam int STRIDE_W   = 17;
   localparam int PROD_W     = IDX_W + STRIDE_W;
   localparam int REM_CNT_W  = $clog2(ADDR_BITS);
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;
   localparam int REG_IDX_W  = 2;

   typedef enum logic [1:0] {
      OP_INIT    = 2'd0,
      OP_ALLOC   = 2'd1,
      OP_RELEASE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_BAD   = 2'd2
   } status_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_BLOCK_COUNT = 2'd0,
      REG_BLOCK_BYTES = 2'd1,
      REG_ALIGN_BYTES = 2'd2,
      REG_POOL_BASE   = 2'd3
   } reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DIV_ELEM,
      S_DIV_BASE,
      S_LINK,
      S_FIN,
      S_HOLD
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0]     block_count;
      logic [BYTES_W-1:0]   block_bytes;
      logic [ALIGN_W-1:0]   align_bytes;
      logic [ADDR_BITS-1:0] pool_base;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [IDX_W-1:0]     block_index;
      logic [ADDR_BITS-1:0] block_address;
      logic [CNT_W-1:0]     free_blocks;
      logic [CNT_W-1:0]     allocated_blocks;
   } res_type;

endpackage

// File: rtl/core/fbpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fbpa_rem.sv
// Iterative remainder unit: one dividend bit per cycle, used by pool init
// for the alignment padding and the base round-up. Depends on fbpa_pkg.
module fbpa_rem
   import fbpa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ADDR_BITS-1:0] dividend,
   input  logic [ALIGN_W-1:0]   divisor,
   output logic                 busy,
   output logic                 done,
   output logic [ALIGN_W-1:0]   remainder
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_BITS-1:0] shift_ff, shift_in;
   logic [ALIGN_W-1:0]   rem_ff, rem_in;
   logic [ALIGN_W-1:0]   div_ff, div_in;
   logic [ALIGN_W:0]     partial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      partial  = {rem_ff, shift_ff[ADDR_BITS-1]};
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (partial >= {1'b0, div_ff}) begin
            rem_in = ALIGN_W'(partial - {1'b0, div_ff});
         end else begin
            rem_in = partial[ALIGN_W-1:0];
         end
         shift_in = {shift_ff[ADDR_BITS-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == REM_CNT_W'(ADDR_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

   // The controller only starts a new division once the previous one is done.
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit started while busy");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (done_ff && div_ff != '0) |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

endmodule

// File: rtl/core/fbpa_csr.sv
// Configuration registers of the pool allocator behind an APB-style port.
// Depends on fbpa_pkg for the register map and the cfg_type struct.
module fbpa_csr
   import fbpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type               cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx = csr_paddr[CSR_ADDR_W-1:3];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_BLOCK_COUNT: cfg_in.block_count = csr_pwdata[CNT_W-1:0];
            REG_BLOCK_BYTES: cfg_in.block_bytes = csr_pwdata[BYTES_W-1:0];
            REG_ALIGN_BYTES: cfg_in.align_bytes = csr_pwdata[ALIGN_W-1:0];
            REG_POOL_BASE:   cfg_in.pool_base   = csr_pwdata[ADDR_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BLOCK_COUNT: csr_prdata = CSR_DATA_W'(cfg_ff.block_count);
         REG_BLOCK_BYTES: csr_prdata = CSR_DATA_W'(cfg_ff.block_bytes);
         REG_ALIGN_BYTES: csr_prdata = CSR_DATA_W'(cfg_ff.align_bytes);
         REG_POOL_BASE:   csr_prdata = CSR_DATA_W'(cfg_ff.pool_base);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_count <= CNT_W'(MAX_BLOCKS);
         cfg_ff.block_bytes <= BYTES_W'(64);
         cfg_ff.align_bytes <= '0;
         cfg_ff.pool_base   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// File: rtl/core/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: control FSM, free-list
// datapath and output register. Depends on fbpa_pkg, fbpa_ram, fbpa_rem and fbpa_csr.
//
//   channel  | dir | handshake            | payload
//   req      | in  | req_valid/req_ready  | operation, release_index
//   rsp      | out | rsp_valid/rsp_ready  | status, block_index, block_address,
//            |     |                      | free_blocks, allocated_blocks
//   csr      | in  | psel/penable/pready  | paddr, pwdata, prdata (64 bit)
//
// For allocate, release and rejected transactions the link memory
// read and the index-times-stride product are issued at accept, the pop or
// push is done in the next cycle. When alignment is set, init runs the
// remainder unit twice at one bit per cycle; it then writes the link memory
// one entry a cycle.
// Reset is synchronous; the link memory needs no clearing pass.
// A result waiting in the output register does not stop the next accept;
// only a second finished result waits in the hold register.
module fixed_block_pool_allocator_top
   import fbpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [IDX_W-1:0]      req_release_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [IDX_W-1:0]      rsp_block_index,
   output logic [ADDR_BITS-1:0]  rsp_block_address,
   output logic [CNT_W-1:0]      rsp_free_blocks,
   output logic [CNT_W-1:0]      rsp_allocated_blocks,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   state_type            state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [IDX_W-1:0]     rel_ff, rel_in;
   logic [CNT_W-1:0]     free_head_ff, free_head_in;
   logic [CNT_W-1:0]     free_total_ff, free_total_in;
   logic [CNT_W-1:0]     alloc_total_ff, alloc_total_in;
   logic [CNT_W-1:0]     pool_size_ff, pool_size_in;
   logic                 pool_ready_ff, pool_ready_in;
   logic [STRIDE_W-1:0]  stride_ff, stride_in;
   logic [ADDR_BITS-1:0] aligned_base_ff, aligned_base_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [CNT_W-1:0]     link_cnt_ff, link_cnt_in;
   res_type              hold_ff, hold_in;
   res_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // FSM outputs
   logic accept;
   logic in_exec;
   logic in_link;
   logic emit;

   logic                 out_free;
   logic                 alloc_ok;
   logic                 rel_ok;
   logic                 align_zero;
   logic [CNT_W-1:0]     size_sat;
   logic [CNT_W-1:0]     link_next;
   logic                 link_last;
   logic [STRIDE_W-1:0]  elem_bytes;
   logic [ADDR_BITS-1:0] base_up;
   res_type              res_exec;
   res_type              res_fin;
   res_type              res_sel;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   logic [CNT_W-1:0]     ram_wdata;
   logic [CNT_W-1:0]     ram_rdata;

   logic                 rem_start;
   logic [ADDR_BITS-1:0] rem_dividend;
   logic                 rem_busy;
   logic                 rem_done;
   logic [ALIGN_W-1:0]   rem_value;

   fbpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fbpa_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (free_head_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   fbpa_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_dividend),
      .divisor   (cfg.align_bytes),
      .busy      (rem_busy),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign align_zero = (cfg.align_bytes == '0);
   assign size_sat   = (cfg.block_count > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                               : cfg.block_count;
   assign alloc_ok   = pool_ready_ff && (free_head_ff < pool_size_ff)
                       && (free_total_ff != '0);
   assign rel_ok     = pool_ready_ff && ({1'b0, rel_ff} < pool_size_ff)
                       && (alloc_total_ff != '0);

   // Element size with padding; the padding is a full align when already aligned.
   assign elem_bytes = STRIDE_W'({1'b0, cfg.block_bytes})
                       + STRIDE_W'(cfg.align_bytes) - STRIDE_W'(rem_value);
   assign base_up    = cfg.pool_base + ADDR_BITS'(cfg.align_bytes) - ADDR_BITS'(1);

   assign link_next  = link_cnt_ff + 1'b1;
   assign link_last  = (link_next == pool_size_ff);

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_ff == OP_INIT) begin
               if (!align_zero) begin
                  state_in = S_DIV_ELEM;
               end else if (size_sat != '0) begin
                  state_in = S_LINK;
               end else begin
                  state_in = S_FIN;
               end
            end else if (out_free) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_HOLD;
            end
         end
         S_DIV_ELEM: begin
            if (rem_done) begin
               state_in = S_DIV_BASE;
            end
         end
         S_DIV_BASE: begin
            if (rem_done) begin
               state_in = (pool_size_ff != '0) ? S_LINK : S_FIN;
            end
         end
         S_LINK: begin
            if (link_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN, S_HOLD: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // FSM outputs
   always_comb begin
      req_ready = 1'b0;
      in_exec   = 1'b0;
      in_link   = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_EXEC: begin
            in_exec = 1'b1;
            emit    = (op_ff != OP_INIT);
         end
         S_LINK:       in_link = 1'b1;
         S_FIN, S_HOLD: emit   = 1'b1;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   assign rem_start    = (in_exec && op_ff == OP_INIT && !align_zero)
                         || (state_ff == S_DIV_ELEM && rem_done);
   assign rem_dividend = (state_ff == S_DIV_ELEM)
                         ? base_up
                         : ADDR_BITS'({1'b0, cfg.block_bytes} + (BYTES_W + 1)'(LINK_NODE_BYTES));

   assign ram_we    = in_link || (in_exec && op_ff == OP_RELEASE && rel_ok);
   assign ram_waddr = in_link ? link_cnt_ff[IDX_W-1:0] : rel_ff;
   assign ram_wdata = in_link ? (link_last ? CNT_W'(MAX_BLOCKS) : link_next)
                              : free_head_ff;

   // Free-list state updates
   always_comb begin
      op_in           = op_ff;
      rel_in          = rel_ff;
      prod_in         = prod_ff;
      free_head_in    = free_head_ff;
      free_total_in   = free_total_ff;
      alloc_total_in  = alloc_total_ff;
      pool_size_in    = pool_size_ff;
      pool_ready_in   = pool_ready_ff;
      stride_in       = stride_ff;
      aligned_base_in = aligned_base_ff;
      link_cnt_in     = link_cnt_ff;

      res_exec.status           = ST_BAD;
      res_exec.block_index      = '0;
      res_exec.block_address    = '0;

      if (accept) begin
         op_in   = req_operation;
         rel_in  = req_release_index;
         prod_in = PROD_W'(free_head_ff[IDX_W-1:0]) * PROD_W'(stride_ff);
      end

      if (in_exec) begin
         case (op_ff)
            OP_INIT: begin
               pool_size_in   = size_sat;
               free_head_in   = (size_sat != '0) ? '0 : CNT_W'(MAX_BLOCKS);
               free_total_in  = size_sat;
               alloc_total_in = '0;
               pool_ready_in  = 1'b1;
               link_cnt_in    = '0;
               if (align_zero) begin
                  stride_in       = STRIDE_W'(cfg.block_bytes) + STRIDE_W'(LINK_NODE_BYTES);
                  aligned_base_in = cfg.pool_base;
               end
            end
            OP_ALLOC: begin
               if (!pool_ready_ff) begin
                  res_exec.status = ST_BAD;
               end else if (!alloc_ok) begin
                  res_exec.status = ST_EMPTY;
               end else begin
                  // The link read was issued at accept, so ram_rdata is the new head.
                  free_head_in           = ram_rdata;
                  free_total_in          = free_total_ff - 1'b1;
                  alloc_total_in         = alloc_total_ff + 1'b1;
                  res_exec.status        = ST_OK;
                  res_exec.block_index   = free_head_ff[IDX_W-1:0];
                  res_exec.block_address = aligned_base_ff + ADDR_BITS'(prod_ff);
               end
            end
            OP_RELEASE: begin
               if (rel_ok) begin
                  free_head_in    = {1'b0, rel_ff};
                  free_total_in   = free_total_ff + 1'b1;
                  alloc_total_in  = alloc_total_ff - 1'b1;
                  res_exec.status = ST_OK;
               end
            end
            default: res_exec.status = ST_BAD;
         endcase
      end

      if (state_ff == S_DIV_ELEM && rem_done) begin
         stride_in = elem_bytes + STRIDE_W'(LINK_NODE_BYTES);
      end
      if (state_ff == S_DIV_BASE && rem_done) begin
         aligned_base_in = base_up - ADDR_BITS'(rem_value);
      end
      if (in_link) begin
         link_cnt_in = link_next;
      end

      res_exec.free_blocks      = free_total_in;
      res_exec.allocated_blocks = alloc_total_in;
   end

   always_comb begin
      res_fin.status           = ST_OK;
      res_fin.block_index      = '0;
      res_fin.block_address    = '0;
      res_fin.free_blocks      = free_total_ff;
      res_fin.allocated_blocks = alloc_total_ff;
   end

   always_comb begin
      case (state_ff)
         S_EXEC:  res_sel = res_exec;
         S_FIN:   res_sel = res_fin;
         default: res_sel = hold_ff;
      endcase
   end

   assign hold_in      = in_exec ? res_exec : hold_ff;
   assign rsp_in       = (emit && out_free) ? res_sel : rsp_ff;
   assign rsp_valid_in = (emit && out_free) ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         free_head_ff    <= CNT_W'(MAX_BLOCKS);
         free_total_ff   <= '0;
         alloc_total_ff  <= '0;
         pool_size_ff    <= '0;
         pool_ready_ff   <= 1'b0;
         stride_ff       <= '0;
         aligned_base_ff <= '0;
         link_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         free_head_ff    <= free_head_in;
         free_total_ff   <= free_total_in;
         alloc_total_ff  <= alloc_total_in;
         pool_size_ff    <= pool_size_in;
         pool_ready_ff   <= pool_ready_in;
         stride_ff       <= stride_in;
         aligned_base_ff <= aligned_base_in;
         link_cnt_ff     <= link_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      rel_ff  <= rel_in;
      prod_ff <= prod_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_ff.status;
   assign rsp_block_index      = rsp_ff.block_index;
   assign rsp_block_address    = rsp_ff.block_address;
   assign rsp_free_blocks      = rsp_ff.free_blocks;
   assign rsp_allocated_blocks = rsp_ff.allocated_blocks;

   // Every block is either on the free list or handed out.
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, free_total_ff} + {1'b0, alloc_total_ff}) == {1'b0, pool_size_ff})
      else $error("free and allocated counts do not add up to the pool size");

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff == CNT_W'(MAX_BLOCKS)) || (free_head_ff < pool_size_ff))
      else $error("free list head outside the pool");

   // A result only waits in the hold register behind a full output register.
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> rsp_valid_ff)
      else $error("hold state with an empty output register");

   // The remainder unit only runs while an init works out the pool geometry.
   a_rem_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !rem_busy)
      else $error("remainder unit busy while idle");

endmodule
